// ----- sv/gsr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the streaming GCD reducer.
// No dependencies; imported by gsr_core and gcd_stream_reduce.
package gsr_pkg;

   // Default datapath width of the running GCD
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed widths of the item fields on the ports
   localparam int VALUE_WIDTH   = 32;
   localparam int DIVISOR_WIDTH = 32;

   // Control from the sequencer to the GCD unit
   typedef struct packed {
      logic start;
   } gsr_ctl_type;

   // Status from the GCD unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } gsr_stat_type;

endpackage

// ----- sv/gsr_core.sv -----
`timescale 1ns / 1ps
// Iterative binary GCD unit: one shift, swap or subtract per cycle.
// Depends on gsr_pkg for the control and status structs.
module gsr_core #(
   parameter int DATA_WIDTH = gsr_pkg::DATA_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gsr_pkg::gsr_ctl_type     ctl,
   input  logic [DATA_WIDTH-1:0]    opnd_a,
   input  logic [DATA_WIDTH-1:0]    opnd_b,
   output gsr_pkg::gsr_stat_type    stat,
   output logic [DATA_WIDTH-1:0]    result
);
   import gsr_pkg::*;

   localparam int KW = $clog2(DATA_WIDTH + 1);

   typedef enum logic [1:0] {
      C_IDLE,
      C_RUN,
      C_SHIFT,
      C_DONE
   } core_state_type;

   core_state_type        state_ff, state_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]         k_ff, k_in;

   // Shared subtractor; its borrow doubles as the magnitude compare
   logic [DATA_WIDTH:0]   sub;
   logic                  borrow;

   assign sub    = {1'b0, a_ff} - {1'b0, b_ff};
   assign borrow = sub[DATA_WIDTH];

   // Sequence the reduction steps
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               a_in     = opnd_a;
               b_in     = opnd_b;
               k_in     = '0;
               state_in = C_RUN;
            end
         end
         C_RUN: begin
            if (a_ff == '0) begin
               // gcd(0, b) = b; move it to a for the fixup
               a_in     = b_ff;
               state_in = C_SHIFT;
            end else if (b_ff == '0) begin
               state_in = C_SHIFT;
            end else if (!a_ff[0] && !b_ff[0]) begin
               // pull out a common factor of two
               a_in = {1'b0, a_ff[DATA_WIDTH-1:1]};
               b_in = {1'b0, b_ff[DATA_WIDTH-1:1]};
               k_in = k_ff + KW'(1);
            end else if (!a_ff[0]) begin
               a_in = {1'b0, a_ff[DATA_WIDTH-1:1]};
            end else if (!b_ff[0]) begin
               b_in = {1'b0, b_ff[DATA_WIDTH-1:1]};
            end else if (borrow) begin
               // keep the larger operand in a
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               a_in = sub[DATA_WIDTH-1:0];
            end
         end
         C_SHIFT: begin
            // restore the common powers of two, one per cycle
            if (k_ff == '0) begin
               state_in = C_DONE;
            end else begin
               a_in = {a_ff[DATA_WIDTH-2:0], 1'b0};
               k_in = k_ff - KW'(1);
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   // Hold state and operands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = (state_ff == C_DONE);
   assign result    = a_ff;

   // A start in idle always launches a run
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_IDLE && ctl.start) |=> (state_ff == C_RUN))
      else $error("gsr_core: start did not launch a run");

   // Done lasts a single cycle
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("gsr_core: done held longer than one cycle");

   // Common factor of two is counted
   a_k_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_RUN && a_ff != '0 && b_ff != '0 && !a_ff[0] && !b_ff[0])
      |=> (k_ff == $past(k_ff) + KW'(1)))
      else $error("gsr_core: common factor of two not counted");

   // Fixup never leaves while shifts are still pending
   a_shift_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_SHIFT && k_ff != '0) |=> (state_ff == C_SHIFT))
      else $error("gsr_core: left fixup with shifts pending");

endmodule

// ----- sv/gcd_stream_reduce.sv -----
`timescale 1ns / 1ps
// Each item is folded by the binary GCD unit doing one shift, swap or subtract per cycle.
// Throughput: one item at a time; req_stall is high until the fold of the item ends,
// and for the last item of a set until its result enters the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears the running GCD to zero and empties the output.
// Top level of the streaming GCD reducer; depends on gsr_pkg and gsr_core.
module gcd_stream_reduce #(
   parameter int DATA_WIDTH = gsr_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gsr_pkg::VALUE_WIDTH-1:0]   req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gsr_pkg::DIVISOR_WIDTH-1:0] rsp_divisor
);
   import gsr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_EMIT
   } top_state_type;

   top_state_type               state_ff, state_in;
   logic [DATA_WIDTH-1:0]       running_ff, running_in;
   logic                        last_ff, last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DIVISOR_WIDTH-1:0]    rsp_divisor_ff, rsp_divisor_in;

   gsr_ctl_type                 ctl;
   gsr_stat_type                stat;
   logic [DATA_WIDTH-1:0]       core_result;
   logic [DATA_WIDTH-1:0]       value_ext;
   logic [DATA_WIDTH+VALUE_WIDTH-1:0]   value_wide;
   logic [DATA_WIDTH+DIVISOR_WIDTH-1:0] running_wide;
   logic                        accept;
   logic                        slot_free;

   // Fit the item value and the result to the datapath and field widths
   assign value_wide   = {{DATA_WIDTH{1'b0}}, req_value};
   assign value_ext    = value_wide[DATA_WIDTH-1:0];
   assign running_wide = {{DIVISOR_WIDTH{1'b0}}, running_ff};

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign ctl.start = accept;

   gsr_core #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .opnd_a (running_ff),
      .opnd_b (value_ext),
      .stat   (stat),
      .result (core_result)
   );

   // Sequence one item: fold, then emit on the last item of a set
   always_comb begin
      state_in       = state_ff;
      running_in     = running_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_divisor_in = rsp_divisor_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in  = req_last;
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (stat.done) begin
               running_in = core_result;
               state_in   = last_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            // hold until the output register frees up
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = running_wide[DIVISOR_WIDTH-1:0];
               running_in     = '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, running GCD and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff        <= last_in;
      rsp_divisor_ff <= rsp_divisor_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = rsp_divisor_ff;

   // Core is only started from idle and never while it is busy
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !stat.busy)
      else $error("gcd_stream_reduce: core started while busy");

   // A non-last item returns to idle without a result
   a_fold_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY && stat.done && !last_ff)
      |=> (state_ff == S_IDLE && rsp_valid_ff == $past(rsp_valid_ff && rsp_stall)))
      else $error("gcd_stream_reduce: result produced for non-last item");

   // Emitting loads the output and clears the running GCD
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && slot_free) |=> (rsp_valid_ff && running_ff == '0))
      else $error("gcd_stream_reduce: emit did not load output and clear");

   // The core is busy whenever an item is being folded
   a_busy_core: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> stat.busy)
      else $error("gcd_stream_reduce: folding with an idle core");

endmodule
